// ===== hdl/vff_pkg.sv =====
// Shared types, format codes and conversion helpers for the vertex format converter.
package vff_pkg;

	localparam logic [3:0] OP_F32       = 4'd0;
	localparam logic [3:0] OP_RG16UNORM = 4'd1;
	localparam logic [3:0] OP_RGBA8UNORM = 4'd2;
	localparam logic [3:0] OP_RG16SNORM = 4'd3;
	localparam logic [3:0] OP_RGB10A2   = 4'd4;
	localparam logic [3:0] OP_RGBA16UINT = 4'd5;
	localparam logic [3:0] OP_RGBA16HALF = 4'd6;
	localparam logic [3:0] OP_RGBA8UINT = 4'd7;
	localparam logic [3:0] OP_R32UINT   = 4'd8;

	localparam logic [31:0] F32_ONE = 32'h3F80_0000;

	typedef enum logic [2:0] {
		K_ZERO,
		K_PASS,
		K_NORM,
		K_UINT,
		K_HALF
	} lane_kind_t;

	typedef struct packed {
		lane_kind_t  kind;
		logic [4:0]  period;
		logic        neg;
		logic [31:0] val;
	} lane_cmd_t;

	function automatic logic [5:0] lead_zeros32(input logic [31:0] v);
		logic [5:0] lz;
		lz = 6'd32;
		for (int j = 0; j < 32; j++) begin
			if (v[j]) lz = 6'(31 - j);
		end
		return lz;
	endfunction

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic        s;
		logic [4:0]  e;
		logic [9:0]  m;
		logic [3:0]  k;
		logic [10:0] ms;
		logic [31:0] r;
		s = h[15];
		e = h[14:10];
		m = h[9:0];
		k = 4'd0;
		for (int j = 0; j < 10; j++) begin
			if (m[j]) k = 4'(10 - j);
		end
		ms = {1'b0, m} << k;
		if (e == 5'd0) begin
			if (m == 10'd0) r = {s, 31'd0};
			else r = {s, 8'd113 - {4'd0, k}, ms[9:0], 13'd0};
		end else if (e == 5'd31) begin
			r = {s, 8'hFF, m, 13'd0} | {9'd0, (m != 10'd0), 22'd0};
		end else begin
			r = {s, {3'd0, e} + 8'd112, m, 13'd0};
		end
		return r;
	endfunction

	function automatic logic [47:0] repeat_frac(input logic [31:0] v, input logic [4:0] n);
		logic [47:0] f;
		unique case (n)
			5'd2:    f = {24{v[1:0]}};
			5'd8:    f = {6{v[7:0]}};
			5'd10:   f = {v[9:0], v[9:0], v[9:0], v[9:0], v[9:2]};
			5'd15:   f = {v[14:0], v[14:0], v[14:0], v[14:12]};
			default: f = {3{v[15:0]}};
		endcase
		return f;
	endfunction

endpackage

// ===== hdl/vff_lane.sv =====
// One conversion lane: leading-zero search, then normalise, round and pack.
module vff_lane (
	input  logic                clk,
	input  logic                en,
	input  vff_pkg::lane_cmd_t  cmd,
	output logic [31:0]         result
);

	vff_pkg::lane_cmd_t cmd_s2;
	logic [5:0]         lz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd;
			lz_s2  <= vff_pkg::lead_zeros32(cmd.val);
		end
	end

	logic [16:0] denom;
	logic [5:0]  lzf;
	logic [47:0] frac;
	logic [47:0] frac_sh;
	logic [30:0] norm_sum;
	logic [31:0] ushift;
	logic        urnd;
	logic [30:0] uint_sum;

	always_comb begin
		denom    = (17'd1 << cmd_s2.period) - 17'd1;
		lzf      = lz_s2 - (6'd32 - {1'b0, cmd_s2.period});
		frac     = vff_pkg::repeat_frac(cmd_s2.val, cmd_s2.period);
		frac_sh  = frac << lzf[3:0];
		norm_sum = {8'd126 - {4'd0, lzf[3:0]}, frac_sh[46:24]} + {30'd0, frac_sh[23]};
		ushift   = cmd_s2.val << lz_s2[4:0];
		urnd     = ushift[7] & ((|ushift[6:0]) | ushift[8]);
		uint_sum = {8'd158 - {2'd0, lz_s2}, ushift[30:8]} + {30'd0, urnd};
		unique case (cmd_s2.kind)
			vff_pkg::K_PASS: result = cmd_s2.val;
			vff_pkg::K_NORM: begin
				if (cmd_s2.val == 32'd0) result = 32'd0;
				else if (cmd_s2.val >= {15'd0, denom}) result = {cmd_s2.neg, vff_pkg::F32_ONE[30:0]};
				else result = {cmd_s2.neg, norm_sum};
			end
			vff_pkg::K_UINT: result = (cmd_s2.val == 32'd0) ? 32'd0 : {1'b0, uint_sum};
			vff_pkg::K_HALF: result = vff_pkg::half_to_single(cmd_s2.val[15:0]);
			default:         result = 32'd0;
		endcase
	end

endmodule

// ===== hdl/vertex_format_to_float.sv =====
// Top level: input stage, four conversion lanes and the merging output stage.
// An accepted item passes the input register, the lane stage register and the output register.
// Throughput: one item per cycle while the output is not stalled; each lane has a two-stage convert path.
// All stages advance together whenever the output register is empty or taken.
// Reset: arst_n clears all valid flags asynchronously; payload is not reset.
module vertex_format_to_float (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  opcode,
	input  logic [2:0]  component_count,
	input  logic [63:0] data_lo,
	input  logic [63:0] data_hi,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] comp_x,
	output logic [31:0] comp_y,
	output logic [31:0] comp_z,
	output logic [31:0] comp_w,
	output logic [2:0]  valid_components,
	output logic        format_error
);

	logic        en;
	logic        valid_s1, valid_s2, valid_q;
	logic [3:0]  op_s1;
	logic [2:0]  cnt_s1;
	logic [63:0] lo_s1, hi_s1;
	logic [2:0]  vc_s2, vc_q;
	logic        err_s2, err_q;
	logic [31:0] comp_q [4];
	logic [31:0] lane_res [4];
	vff_pkg::lane_cmd_t cmd [4];
	logic [2:0]  cnt_sat;
	logic        err;

	assign en       = !(valid_q && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= opcode;
			cnt_s1 <= component_count;
			lo_s1  <= data_lo;
			hi_s1  <= data_hi;
			vc_s2  <= err ? 3'd0 : ((op_s1 == vff_pkg::OP_RGB10A2) ? 3'd4 : cnt_sat);
			err_s2 <= err;
			vc_q   <= vc_s2;
			err_q  <= err_s2;
			for (int i = 0; i < 4; i++) comp_q[i] <= lane_res[i];
		end
	end

	assign cnt_sat = (cnt_s1 > 3'd4) ? 3'd4 : cnt_s1;
	assign err     = (op_s1 > vff_pkg::OP_R32UINT);

	for (genvar i = 0; i < 4; i++) begin : g_lane
		logic [31:0] word;
		logic [15:0] f16;
		logic [7:0]  f8;
		logic [15:0] mag;
		logic        active;

		assign word   = (i < 2) ? lo_s1[32*(i%2) +: 32] : hi_s1[32*(i%2) +: 32];
		assign f16    = lo_s1[16*i +: 16];
		assign f8     = lo_s1[8*i +: 8];
		assign mag    = f16[15] ? (16'd0 - f16) : f16;
		assign active = (op_s1 == vff_pkg::OP_RGB10A2) || (3'(i) < cnt_sat);

		always_comb begin
			cmd[i].kind   = vff_pkg::K_ZERO;
			cmd[i].period = 5'd16;
			cmd[i].neg    = 1'b0;
			cmd[i].val    = {16'd0, f16};
			unique case (op_s1)
				vff_pkg::OP_F32: begin
					cmd[i].kind = vff_pkg::K_PASS;
					cmd[i].val  = word;
				end
				vff_pkg::OP_RG16UNORM: cmd[i].kind = vff_pkg::K_NORM;
				vff_pkg::OP_RGBA8UNORM: begin
					cmd[i].kind   = vff_pkg::K_NORM;
					cmd[i].period = 5'd8;
					cmd[i].val    = {24'd0, f8};
				end
				vff_pkg::OP_RG16SNORM: begin
					cmd[i].kind   = vff_pkg::K_NORM;
					cmd[i].period = 5'd15;
					cmd[i].neg    = f16[15];
					cmd[i].val    = {16'd0, mag};
				end
				vff_pkg::OP_RGB10A2: begin
					cmd[i].kind = vff_pkg::K_NORM;
					if (i == 3) begin
						cmd[i].period = 5'd2;
						cmd[i].val    = {30'd0, lo_s1[31:30]};
					end else begin
						cmd[i].period = 5'd10;
						cmd[i].val    = {22'd0, lo_s1[10*(i%3) +: 10]};
					end
				end
				vff_pkg::OP_RGBA16UINT: cmd[i].kind = vff_pkg::K_UINT;
				vff_pkg::OP_RGBA16HALF: cmd[i].kind = vff_pkg::K_HALF;
				vff_pkg::OP_RGBA8UINT: begin
					cmd[i].kind = vff_pkg::K_UINT;
					cmd[i].val  = {24'd0, f8};
				end
				vff_pkg::OP_R32UINT: begin
					cmd[i].kind = vff_pkg::K_UINT;
					cmd[i].val  = word;
				end
				default: cmd[i].kind = vff_pkg::K_ZERO;
			endcase
			if (!active) cmd[i].kind = vff_pkg::K_ZERO;
		end

		vff_lane u_lane (
			.clk    (clk),
			.en     (en),
			.cmd    (cmd[i]),
			.result (lane_res[i])
		);
	end

	assign out_valid        = valid_q;
	assign comp_x           = comp_q[0];
	assign comp_y           = comp_q[1];
	assign comp_z           = comp_q[2];
	assign comp_w           = comp_q[3];
	assign valid_components = vc_q;
	assign format_error     = err_q;

endmodule
